### hdl/rlgr_pkg.sv
package rlgr_pkg;

  // Fixed port widths of the recorder channels.
  localparam int IO_SAMPLE_W = 22;
  localparam int TOUCH_W     = 2;

  localparam logic [TOUCH_W-1:0] TOUCH_NONE = 2'd0;
  localparam logic [TOUCH_W-1:0] TOUCH_ONE  = 2'd1;

  // Per-request result handed from the recorder core to the output side.
  // When use_play is set, the value field is not used: the output takes the
  // playback sample that the core resolves once the store read has returned.
  typedef struct packed {
    logic                   valid;
    logic                   use_play;
    logic [IO_SAMPLE_W-1:0] value;
  } rlgr_res_t;

endpackage

### hdl/run_length_gesture_recorder_top.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  touch_count, sample, gate_in, button_in
// out_      output     out_valid / out_stall value, valid_res
// cfg_      input      cfg_valid / cfg_ready loop_playback
//
// One request is accepted every clock cycle when the output side keeps up;
// its result passes through the middle stage into the output register before
// it is on the out_ ports. The middle stage holds each request while it
// waits for the registered read of the run store that a playback fetch needs.
// Reset is synchronous on rst_n low and clears all pointers, flags and runs;
// the store contents stay undefined until written.
// A stalled result holds in the output register while one more request can
// wait in the middle stage; only then is in_stall raised.
module run_length_gesture_recorder_top
  import rlgr_pkg::*;
#(
  parameter int STORE_DEPTH = 1024,
  parameter int REPEAT_BITS = 10,
  parameter int SAMPLE_BITS = 22
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TOUCH_W-1:0]     in_touch_count,
  input  logic [IO_SAMPLE_W-1:0] in_sample,
  input  logic                   in_gate_in,
  input  logic                   in_button_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [IO_SAMPLE_W-1:0] out_value,
  output logic                   out_valid_res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_loop_playback
);

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int WORD_W = REPEAT_BITS + SAMPLE_BITS;

  logic                   loop_r;
  logic                   accept;
  logic                   mid_v_r;
  rlgr_res_t              mid_r;
  logic                   mid_go;
  logic                   out_v_r;
  logic [IO_SAMPLE_W-1:0] out_value_r;
  logic                   out_valid_res_r;

  rlgr_res_t              core_res;
  logic [IO_SAMPLE_W-1:0] play_value;
  logic                   wr_en, rd_en;
  logic [IDX_W-1:0]       wr_addr, rd_addr;
  logic [WORD_W-1:0]      wr_data, rd_data;

  // The configuration register is always writable; the user must write it only
  // while the recorder is idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // The middle stage waits for the store read; it drains into the output
  // register whenever that register is empty or being taken.
  assign mid_go   = mid_v_r && (!out_v_r || !out_stall);
  assign in_stall = mid_v_r && !mid_go;
  assign accept   = in_valid && !in_stall;

  rlgr_core #(
    .STORE_DEPTH (STORE_DEPTH),
    .REPEAT_BITS (REPEAT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .touch_count   (in_touch_count),
    .sample        (in_sample),
    .gate_in       (in_gate_in),
    .button_in     (in_button_in),
    .loop_playback (loop_r),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .res           (core_res),
    .play_value    (play_value)
  );

  rlgr_store #(
    .DEPTH  (STORE_DEPTH),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r          <= 1'b1;
      mid_v_r         <= 1'b0;
      out_v_r         <= 1'b0;
      mid_r           <= '0;
      out_value_r     <= '0;
      out_valid_res_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        loop_r <= cfg_loop_playback;
      end

      if (accept) begin
        mid_v_r <= 1'b1;
        mid_r   <= core_res;
      end else if (mid_go) begin
        mid_v_r <= 1'b0;
      end

      if (mid_go) begin
        out_v_r         <= 1'b1;
        out_valid_res_r <= mid_r.valid;
        // Playback requests take the sample resolved after the store read.
        if (mid_r.use_play) begin
          out_value_r <= play_value;
        end else begin
          out_value_r <= mid_r.value;
        end
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_v_r;
  assign out_value     = out_value_r;
  assign out_valid_res = out_valid_res_r;

endmodule

### hdl/rlgr_store.sv
module rlgr_store #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write-first: a read of the word being written returns the new data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/rlgr_core.sv
module rlgr_core
  import rlgr_pkg::*;
#(
  parameter int STORE_DEPTH = 1024,
  parameter int REPEAT_BITS = 10,
  parameter int SAMPLE_BITS = 22
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [TOUCH_W-1:0]                   touch_count,
  input  logic [IO_SAMPLE_W-1:0]               sample,
  input  logic                                 gate_in,
  input  logic                                 button_in,
  input  logic                                 loop_playback,
  input  logic [REPEAT_BITS+SAMPLE_BITS-1:0]   rd_data,
  output logic                                 wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0]       wr_addr,
  output logic [REPEAT_BITS+SAMPLE_BITS-1:0]   wr_data,
  output logic                                 rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0]       rd_addr,
  output rlgr_res_t                            res,
  output logic [IO_SAMPLE_W-1:0]               play_value
);

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int WORD_W = REPEAT_BITS + SAMPLE_BITS;
  localparam int CMP_W  = (SAMPLE_BITS > IO_SAMPLE_W) ? SAMPLE_BITS : IO_SAMPLE_W;

  localparam logic [REPEAT_BITS-1:0] REP_MAX  = {REPEAT_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX  = {SAMPLE_BITS{1'b1}};
  localparam logic [IDX_W-1:0]       IDX_LAST = IDX_W'(STORE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    if (i == IDX_LAST) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  logic [IDX_W-1:0]       start_r, end_r, cur_r;
  logic                   playing_r, full_r, first_r;
  logic [SAMPLE_BITS-1:0] pend_smp_r, play_smp_r;
  logic [REPEAT_BITS-1:0] pend_rep_r, play_rep_r;
  logic [TOUCH_W-1:0]     prev_touch_r;
  logic                   prev_gate_r, prev_button_r;
  logic                   fetch_pend_r, fetch_zero_r;

  logic [IDX_W-1:0]       start_nxt, end_nxt, cur_nxt;
  logic                   playing_nxt, full_nxt, first_nxt;
  logic [SAMPLE_BITS-1:0] pend_smp_nxt;
  logic [REPEAT_BITS-1:0] pend_rep_nxt, play_rep_nxt;
  logic                   fetch_nxt, fetch_zero_nxt;
  logic                   push;
  logic                   read;

  logic [REPEAT_BITS-1:0] eff_rep;
  logic [SAMPLE_BITS-1:0] eff_smp;
  logic [CMP_W-1:0]       smp_ext, play_ext, rec_ext;
  logic [SAMPLE_BITS-1:0] smp_sat;

  // Playback state as seen by the next request: the word fetched by the
  // previous request lands here the cycle after its read was issued.
  always_comb begin
    if (fetch_pend_r) begin
      if (fetch_zero_r) begin
        eff_rep = '0;
        eff_smp = '0;
      end else begin
        eff_rep = rd_data[REPEAT_BITS-1:0];
        eff_smp = rd_data[WORD_W-1:REPEAT_BITS];
      end
    end else begin
      eff_rep = play_rep_r;
      eff_smp = play_smp_r;
    end
  end

  assign smp_ext    = CMP_W'(sample);
  assign smp_sat    = (smp_ext > CMP_W'(SMP_MAX)) ? SMP_MAX : smp_ext[SAMPLE_BITS-1:0];
  assign play_ext   = CMP_W'(eff_smp);
  assign play_value = play_ext[IO_SAMPLE_W-1:0];
  assign rec_ext    = CMP_W'(smp_sat);

  always_comb begin
    start_nxt      = start_r;
    end_nxt        = end_r;
    cur_nxt        = cur_r;
    playing_nxt    = playing_r;
    full_nxt       = full_r;
    first_nxt      = first_r;
    pend_smp_nxt   = pend_smp_r;
    pend_rep_nxt   = pend_rep_r;
    play_rep_nxt   = eff_rep;
    fetch_nxt      = 1'b0;
    fetch_zero_nxt = 1'b0;
    push           = 1'b0;
    read           = 1'b0;
    wr_addr        = cur_r;
    wr_data        = {pend_smp_r, pend_rep_r};
    rd_addr        = cur_r;
    res            = '0;

    // A trigger edge while untouched restarts playback at the take start.
    if (((gate_in && !prev_gate_r) || (button_in && !prev_button_r)) &&
        (touch_count == TOUCH_NONE)) begin
      playing_nxt = 1'b1;
      cur_nxt     = start_nxt;
    end

    if (touch_count != prev_touch_r) begin
      if ((touch_count == TOUCH_ONE) && (prev_touch_r == TOUCH_NONE)) begin
        first_nxt   = 1'b1;
        playing_nxt = 1'b1;
        start_nxt   = cur_nxt;
        full_nxt    = 1'b0;
      end else if (touch_count == TOUCH_NONE) begin
        // Release: flush the open run and close the take.
        push    = 1'b1;
        wr_addr = cur_nxt;
        wr_data = {pend_smp_nxt, pend_rep_nxt};
        cur_nxt = next_idx(cur_nxt);
        if (cur_nxt == start_nxt) begin
          full_nxt = 1'b1;
        end
        end_nxt = cur_nxt;
        if (full_nxt) begin
          start_nxt = next_idx(end_nxt);
        end
        cur_nxt = start_nxt;
      end
    end

    if (touch_count != TOUCH_NONE) begin
      if (!first_nxt && (pend_smp_nxt == smp_sat) && (pend_rep_nxt != REP_MAX)) begin
        pend_rep_nxt = pend_rep_nxt + REPEAT_BITS'(1);
      end else begin
        if (!first_nxt) begin
          push    = 1'b1;
          wr_addr = cur_nxt;
          wr_data = {pend_smp_nxt, pend_rep_nxt};
          cur_nxt = next_idx(cur_nxt);
          if (cur_nxt == start_nxt) begin
            full_nxt = 1'b1;
          end
        end
        pend_rep_nxt = '0;
        pend_smp_nxt = smp_sat;
      end
      first_nxt      = 1'b0;
      res.valid      = 1'b1;
      res.use_play   = 1'b0;
      res.value      = rec_ext[IO_SAMPLE_W-1:0];
    end else if (start_nxt != end_nxt) begin
      if (eff_rep != '0) begin
        play_rep_nxt = eff_rep - REPEAT_BITS'(1);
      end else begin
        fetch_nxt = 1'b1;
        if (cur_nxt == end_nxt) begin
          if (loop_playback) begin
            cur_nxt = start_nxt;
          end else begin
            playing_nxt = 1'b0;
          end
        end
        if (playing_nxt) begin
          read    = 1'b1;
          rd_addr = cur_nxt;
          cur_nxt = next_idx(cur_nxt);
        end else begin
          fetch_zero_nxt = 1'b1;
        end
      end
      res.valid    = 1'b1;
      res.use_play = 1'b1;
    end
  end

  assign wr_en = accept && push;
  assign rd_en = accept && read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= '0;
      end_r         <= '0;
      cur_r         <= '0;
      playing_r     <= 1'b0;
      full_r        <= 1'b0;
      first_r       <= 1'b0;
      pend_smp_r    <= '0;
      pend_rep_r    <= '0;
      play_smp_r    <= '0;
      play_rep_r    <= '0;
      prev_touch_r  <= TOUCH_NONE;
      prev_gate_r   <= 1'b0;
      prev_button_r <= 1'b0;
      fetch_pend_r  <= 1'b0;
      fetch_zero_r  <= 1'b0;
    end else begin
      play_smp_r <= eff_smp;
      if (accept) begin
        start_r       <= start_nxt;
        end_r         <= end_nxt;
        cur_r         <= cur_nxt;
        playing_r     <= playing_nxt;
        full_r        <= full_nxt;
        first_r       <= first_nxt;
        pend_smp_r    <= pend_smp_nxt;
        pend_rep_r    <= pend_rep_nxt;
        play_rep_r    <= play_rep_nxt;
        prev_touch_r  <= touch_count;
        prev_gate_r   <= gate_in;
        prev_button_r <= button_in;
        fetch_pend_r  <= fetch_nxt;
        fetch_zero_r  <= fetch_zero_nxt;
      end else begin
        play_rep_r   <= eff_rep;
        fetch_pend_r <= 1'b0;
        fetch_zero_r <= 1'b0;
      end
    end
  end

endmodule

### tb/run_length_gesture_recorder_checker.sv
`timescale 1ns / 1ps

module run_length_gesture_recorder_checker
  import rlgr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [TOUCH_W-1:0]     in_touch_count,
  input  logic [IO_SAMPLE_W-1:0] in_sample,
  input  logic                   in_gate_in,
  input  logic                   in_button_in,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [IO_SAMPLE_W-1:0] out_value,
  input  logic                   out_valid_res,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_loop_playback,
  output int                     mismatches,
  output int                     awaiting,
  output int                     results_seen
);

  localparam int RUN_DEPTH = 1024;
  localparam int REP_W     = 10;
  localparam logic [REP_W-1:0] REP_TOP = '1;

  typedef struct packed {
    logic                   valid_res;
    logic [IO_SAMPLE_W-1:0] value;
  } level_result_t;

  // Recorder state mirrored at the block's widths.
  logic [REP_W+IO_SAMPLE_W-1:0] run_words [RUN_DEPTH];
  logic [REP_W-1:0]       take_start, take_end, cursor;
  logic                   playing, wrapped, fresh_take;
  logic [IO_SAMPLE_W-1:0] open_sample, shown_sample;
  logic [REP_W-1:0]       open_repeats, shown_repeats;
  logic [TOUCH_W-1:0]     last_touch;
  logic                   last_gate, last_button;
  logic                   loop_on;

  level_result_t predicted_levels [$];
  int mismatch_total = 0;
  int compared = 0;

  assign mismatches   = mismatch_total;
  assign results_seen = compared;

  task automatic clear_recorder();
    for (int i = 0; i < RUN_DEPTH; i++) run_words[i] = '0;
    take_start = '0;
    take_end = '0;
    cursor = '0;
    playing = 1'b0;
    wrapped = 1'b0;
    fresh_take = 1'b0;
    open_sample = '0;
    shown_sample = '0;
    open_repeats = '0;
    shown_repeats = '0;
    last_touch = TOUCH_NONE;
    last_gate = 1'b0;
    last_button = 1'b0;
    loop_on = 1'b1;
  endtask

  // Store the open run and step the write cursor; reaching the start means
  // the whole ring has been written during this take.
  task automatic close_run();
    run_words[cursor] = {open_sample, open_repeats};
    cursor = cursor + 10'd1;
    if (cursor == take_start) wrapped = 1'b1;
  endtask

  task automatic next_played_word(output logic [REP_W+IO_SAMPLE_W-1:0] word);
    if (cursor == take_end) begin
      if (loop_on) cursor = take_start;
      else playing = 1'b0;
    end
    if (!playing) begin
      word = '0;
    end else begin
      word = run_words[cursor];
      cursor = cursor + 10'd1;
    end
  endtask

  task automatic advance_recorder(input logic [TOUCH_W-1:0] touch,
                                  input logic [IO_SAMPLE_W-1:0] smp,
                                  input logic gate, input logic button,
                                  output level_result_t res);
    logic [REP_W+IO_SAMPLE_W-1:0] word;
    res = '0;
    if ((gate && !last_gate) || (button && !last_button)) begin
      if (touch == TOUCH_NONE) begin
        playing = 1'b1;
        cursor = take_start;
      end
    end
    last_gate = gate;
    last_button = button;

    if (touch != last_touch) begin
      if (touch == TOUCH_ONE && last_touch == TOUCH_NONE) begin
        fresh_take = 1'b1;
        playing = 1'b1;
        take_start = cursor;
        wrapped = 1'b0;
      end else if (touch == TOUCH_NONE) begin
        close_run();
        take_end = cursor;
        if (wrapped) take_start = take_end + 10'd1;
        cursor = take_start;
      end
    end
    last_touch = touch;

    if (touch != TOUCH_NONE) begin
      if (!fresh_take && open_sample == smp && open_repeats != REP_TOP) begin
        open_repeats = open_repeats + 10'd1;
      end else begin
        if (!fresh_take) close_run();
        open_repeats = '0;
        open_sample = smp;
      end
      fresh_take = 1'b0;
      res.value = smp;
      res.valid_res = 1'b1;
    end else if (take_start != take_end) begin
      if (shown_repeats != '0) begin
        shown_repeats = shown_repeats - 10'd1;
      end else begin
        next_played_word(word);
        shown_repeats = word[REP_W-1:0];
        shown_sample = word[REP_W+IO_SAMPLE_W-1:REP_W];
      end
      res.value = shown_sample;
      res.valid_res = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input int idx,
                                 input logic [31:0] want_v, input logic [31:0] got_v);
    mismatch_total++;
    if (mismatch_total <= 40)
      $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
               $time, idx, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : watch
    level_result_t want, fresh;
    if (!rst_n) begin
      clear_recorder();
      predicted_levels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_levels.size() == 0) begin
          report_mismatch("result with nothing pending", compared,
                          32'd0, {{(32-IO_SAMPLE_W){1'b0}}, out_value});
        end else begin
          want = predicted_levels.pop_front();
          if (out_value !== want.value)
            report_mismatch("value", compared,
                            {{(32-IO_SAMPLE_W){1'b0}}, want.value},
                            {{(32-IO_SAMPLE_W){1'b0}}, out_value});
          if (out_valid_res !== want.valid_res)
            report_mismatch("valid_res", compared, {31'd0, want.valid_res},
                            {31'd0, out_valid_res});
        end
        compared++;
      end
      if (cfg_valid && cfg_ready) loop_on = cfg_loop_playback;
      if (in_valid && !in_stall) begin
        advance_recorder(in_touch_count, in_sample, in_gate_in, in_button_in, fresh);
        predicted_levels.insert(predicted_levels.size(), fresh);
      end
    end
    awaiting <= predicted_levels.size();
  end

endmodule

### tb/run_length_gesture_recorder_top_test.sv
`timescale 1ns / 1ps

module run_length_gesture_recorder_top_test;
  import rlgr_pkg::*;

  // Touch counts that the package does not name: two and three fingers.
  localparam logic [TOUCH_W-1:0] TOUCH_TWO   = 2'd2;
  localparam logic [TOUCH_W-1:0] TOUCH_THREE = 2'd3;
  localparam logic [IO_SAMPLE_W-1:0] SAMPLE_TOP = '1;

  // Requests in the random part, the store-filling take included.
  localparam int RANDOM_ITEMS = 1450;
  // About 1500 requests at one per cycle plus sparse gaps, stalls and drains
  // finish far below this limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [TOUCH_W-1:0]     in_touch_count = TOUCH_NONE;
  logic [IO_SAMPLE_W-1:0] in_sample = '0;
  logic                   in_gate_in = 1'b0;
  logic                   in_button_in = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [IO_SAMPLE_W-1:0] out_value;
  logic                   out_valid_res;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_loop_playback = 1'b1;

  int mismatches;
  int awaiting;
  int results_seen;

  // When gaps_on is low, neither side idles: the store-filling take runs
  // through with the pipeline at full rate.
  bit gaps_on = 1'b1;
  logic gate_level = 1'b0;
  logic button_level = 1'b0;
  int items_sent = 0;
  int takes = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  run_length_gesture_recorder_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_touch_count   (in_touch_count),
    .in_sample        (in_sample),
    .in_gate_in       (in_gate_in),
    .in_button_in     (in_button_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_valid_res    (out_valid_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_loop_playback(cfg_loop_playback)
  );

  run_length_gesture_recorder_checker level_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_touch_count   (in_touch_count),
    .in_sample        (in_sample),
    .in_gate_in       (in_gate_in),
    .in_button_in     (in_button_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_valid_res    (out_valid_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_loop_playback(cfg_loop_playback),
    .mismatches       (mismatches),
    .awaiting         (awaiting),
    .results_seen     (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random, with a six percent chance, while gaps are on.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 6);
  end

  // Watchdog: a hung handshake or a result that never arrives ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results still due",
               cycle_count, awaiting);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [IO_SAMPLE_W-1:0] random_sample();
    logic [31:0] r;
    r = $urandom();
    return r[IO_SAMPLE_W-1:0];
  endfunction

  // Offer one request and hold it until the block takes it. Valid stays high
  // between back-to-back requests; it drops only for a random idle gap or a drain.
  task automatic send_request(input logic [TOUCH_W-1:0] touch,
                              input logic [IO_SAMPLE_W-1:0] smp,
                              input logic gate, input logic button);
    if (gaps_on) begin
      while (chance(6)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_touch_count <= touch;
    in_sample      <= smp;
    in_gate_in     <= gate;
    in_button_in   <= button;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold off the sender until the checker has every result it expects.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // The loop_playback register is only written with the block idle.
  task automatic write_loop(input logic setting);
    drain_results();
    cfg_valid         <= 1'b1;
    cfg_loop_playback <= setting;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Trigger levels wander slowly so that rising edges land both while the
  // slider is touched (ignored) and while it is free (restart playback).
  task automatic nudge_levels(input int pct);
    if (chance(pct)) gate_level = ~gate_level;
    if (chance(pct)) button_level = ~button_level;
  endtask

  task automatic play_ticks(input int count);
    for (int k = 0; k < count; k++)
      send_request(TOUCH_NONE, random_sample(), 1'b0, 1'b0);
  endtask

  task automatic playback_stretch();
    int len;
    len = $urandom_range(60, 1);
    for (int k = 0; k < len; k++) begin
      nudge_levels(6);
      send_request(TOUCH_NONE, random_sample(), gate_level, button_level);
    end
  endtask

  // A well-formed take: mostly one finger, runs of equal samples drawn from a
  // small palette so that repeats build up, and a release at the end.
  task automatic record_take();
    logic [IO_SAMPLE_W-1:0] palette [3];
    logic [IO_SAMPLE_W-1:0] smp;
    logic [TOUCH_W-1:0] touch;
    logic [31:0] r;
    int len;
    int roll;
    len = $urandom_range(40, 1);
    for (int p = 0; p < 3; p++) palette[p] = random_sample();
    palette[0] = chance(30) ? SAMPLE_TOP : palette[0];
    smp = palette[$urandom_range(2)];
    r = $urandom_range(3, 2);
    touch = chance(85) ? TOUCH_ONE : r[TOUCH_W-1:0];
    for (int k = 0; k < len; k++) begin
      roll = $urandom_range(99);
      if (roll >= 60 && roll < 85) smp = palette[$urandom_range(2)];
      else if (roll >= 85 && roll < 92) smp = chance(50) ? '0 : SAMPLE_TOP;
      else if (roll >= 92) smp = random_sample();
      if (k > 0 && chance(8)) begin
        r = $urandom_range(3, 1);
        touch = r[TOUCH_W-1:0];
      end
      nudge_levels(5);
      send_request(touch, smp, gate_level, button_level);
    end
    nudge_levels(5);
    send_request(TOUCH_NONE, random_sample(), gate_level, button_level);
    takes++;
  endtask

  // Short bursts of unrelated requests: any touch count, any sample, any
  // trigger levels, including takes that are never released cleanly.
  task automatic noise_burst();
    logic [31:0] r;
    int len;
    len = $urandom_range(8, 1);
    for (int k = 0; k < len; k++) begin
      r = $urandom();
      gate_level = r[2];
      button_level = r[3];
      send_request(r[TOUCH_W-1:0], chance(20) ? SAMPLE_TOP : random_sample(),
                   gate_level, button_level);
    end
  endtask

  // A take in which each sample differs from the one before, writing more words
  // than the store holds, so the start of the take is pushed to just past its end.
  // Both sides run without gaps here.
  task automatic fill_take();
    logic [IO_SAMPLE_W-1:0] smp, last;
    gaps_on <= 1'b0;
    last = '0;
    send_request(TOUCH_NONE, '0, gate_level, button_level);
    for (int k = 0; k < 1040; k++) begin
      smp = random_sample();
      if (smp == last) smp = ~smp;
      send_request(TOUCH_ONE, smp, gate_level, button_level);
      last = smp;
    end
    send_request(TOUCH_NONE, '0, gate_level, button_level);
    play_ticks(60);
    gaps_on <= 1'b1;
    takes++;
  endtask

  initial begin : stimulus
    int base;
    int pick;
    bit long_done;
    long_done = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A rising gate with nothing recorded yet gives an invalid, zero result.
    send_request(TOUCH_NONE, '0, 1'b1, 1'b0);

    // Two and then three fingers without ever passing through one finger:
    // no take starts, but the samples are still coded at the write cursor.
    // The button rises while touched and must be ignored.
    send_request(TOUCH_TWO, '0, 1'b0, 1'b0);
    send_request(TOUCH_THREE, SAMPLE_TOP, 1'b0, 1'b0);
    send_request(TOUCH_TWO, 22'h2AAAAA, 1'b0, 1'b1);
    send_request(TOUCH_NONE, 22'h155555, 1'b0, 1'b0);
    play_ticks(2);

    // A proper take with a run at full scale, a run at zero and a finger
    // count change before the release flushes the last run.
    send_request(TOUCH_ONE, SAMPLE_TOP, 1'b0, 1'b0);
    send_request(TOUCH_ONE, SAMPLE_TOP, 1'b0, 1'b0);
    send_request(TOUCH_ONE, '0, 1'b0, 1'b0);
    send_request(TOUCH_ONE, '0, 1'b0, 1'b0);
    send_request(TOUCH_TWO, 22'h155555, 1'b0, 1'b0);
    send_request(TOUCH_NONE, '0, 1'b0, 1'b0);
    play_ticks(3);

    // A button edge while untouched restarts playback from the take start.
    send_request(TOUCH_NONE, '0, 1'b0, 1'b1);
    send_request(TOUCH_NONE, '0, 1'b0, 1'b0);

    // A take of a single sample released at once, then one-shot playback:
    // after the last word has played out the value reads zero.
    send_request(TOUCH_ONE, 22'h000001, 1'b0, 1'b0);
    send_request(TOUCH_NONE, '0, 1'b0, 1'b0);
    write_loop(1'b0);
    play_ticks(4);

    // A gate edge brings the stopped playback back.
    send_request(TOUCH_NONE, '0, 1'b1, 1'b0);
    send_request(TOUCH_NONE, '0, 1'b0, 1'b0);
    write_loop(1'b1);

    // Random part: well-formed takes and playback dominate, with some noise,
    // register changes and drained pauses mixed in.
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (!long_done && items_sent - base > 150) begin
        fill_take();
        long_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) record_take();
      else if (pick < 80) playback_stretch();
      else if (pick < 90) noise_burst();
      else if (pick < 96) write_loop(chance(50));
      else drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests and %0d results over %0d takes and %0d register writes,",
             items_sent, results_seen, takes, cfg_writes);
    $display("with looped and one-shot playback, trigger restarts and a full store.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
